// File: rtl/rbam_pkg.sv
package rbam_pkg;

    localparam int CHANNELS   = 16;
    localparam int RING_BYTES = 4096;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W      = $clog2(RING_BYTES);
    localparam int ADDR_W     = CH_W + PTR_W;
    localparam int CNT_W      = PTR_W + 1;
    localparam int FILL_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 17 + CH_W;

    typedef enum logic [2:0] {
        FUNC_WRITE  = 3'd0,
        FUNC_TICK   = 3'd1,
        FUNC_LEVEL  = 3'd2,
        FUNC_PLAY   = 3'd3,
        FUNC_CLEAR  = 3'd4,
        FUNC_STATUS = 3'd5
    } func_t;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;
    localparam logic [29:0]       LOG_FACTOR = 30'd631305657;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic gain_start;
        logic gain_store;
        logic scan_clear;
        logic use_scan;
        logic rd_lo;
        logic rd_hi;
        logic mul;
        logic acc;
        logic next_ch;
        logic load_result;
    } rbam_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       ch_valid;
        logic       eligible;
        logic       last_ch;
        logic       gain_done;
    } rbam_sts_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [CNT_W-1:0] s;
        s = {1'b0, p} + CNT_W'(1);
        if (s >= CNT_W'(RING_BYTES))
        begin
            return '0;
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] ring_fill(input logic [PTR_W-1:0] w,
                                                   input logic [PTR_W-1:0] r);
        if (w >= r)
        begin
            return {1'b0, w} - {1'b0, r};
        end
        return {1'b0, w} + CNT_W'(RING_BYTES) - {1'b0, r};
    endfunction

endpackage

// File: rtl/rbam_item_if.sv
interface rbam_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [3:0]         channel;
    logic [7:0]         data_byte;
    logic signed [15:0] level_mb;
    logic               play_flag;
    logic               mute_flag;

    modport source (output valid, func, channel, data_byte, level_mb, play_flag, mute_flag,
                    input ready);
    modport sink (input valid, func, channel, data_byte, level_mb, play_flag, mute_flag,
                  output ready);
endinterface

// File: rtl/rbam_result_if.sv
interface rbam_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mix_sample;
    logic [11:0]        fill_bytes;
    logic               refill_request;
    logic               byte_dropped;

    modport source (output valid, mix_sample, fill_bytes, refill_request, byte_dropped,
                    input ready);
    modport sink (input valid, mix_sample, fill_bytes, refill_request, byte_dropped,
                  output ready);
endinterface

// File: rtl/rbam_gain.sv
module rbam_gain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [15:0]                    level,
    output logic                           done,
    output logic [rbam_pkg::GAIN_W-1:0]    gain
);
    import rbam_pkg::*;

    typedef enum logic [2:0] {
        G_IDLE,
        G_MID,
        G_LOG,
        G_MUL,
        G_CMP
    } gstate_t;

    gstate_t            state_reg;
    logic [15:0]        lo_reg;
    logic [15:0]        hi_reg;
    logic [15:0]        mid_reg;
    logic [15:0]        n_reg;
    logic [28:0]        m_reg;
    logic [3:0]         e_reg;
    logic [27:0]        frac_reg;
    logic [4:0]         it_reg;
    logic [45:0]        pa_reg;
    logic [45:0]        pb_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               done_reg;

    logic [16:0]        mid_sum;
    logic [15:0]        mid_calc;
    logic [3:0]         e_calc;
    logic [28:0]        m_init;
    logic [57:0]        sq;
    logic [29:0]        m2;
    logic [28:0]        m_next;
    logic [31:0]        d;
    logic [62:0]        prod;
    logic               fits;
    logic [16:0]        n_calc;

    always_comb
    begin
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
        mid_calc = mid_sum[16:1];
        e_calc   = '0;
        for (int i = 1; i < 16; i++)
        begin
            if (mid_calc[i])
            begin
                e_calc = 4'(i);
            end
        end
        m_init = 29'({13'd0, mid_calc} << (5'd28 - {1'b0, e_calc}));
        sq     = 58'(m_reg) * 58'(m_reg);
        m2     = sq[57:28];
        m_next = m2[29] ? m2[29:1] : m2[28:0];
        d      = 32'hF000_0000 - {e_reg, frac_reg};
        prod   = {1'b0, pa_reg, 16'd0} + {17'd0, pb_reg};
        fits   = {2'b00, prod[61:48]} >= n_reg;
        n_calc = 17'h10000 - {1'b0, level};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
            gain_reg  <= GAIN_UNITY;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        if (!level[15])
                        begin
                            gain_reg <= GAIN_UNITY;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            n_reg     <= n_calc[15:0];
                            lo_reg    <= '0;
                            hi_reg    <= 16'(GAIN_UNITY);
                            state_reg <= G_MID;
                        end
                    end
                end
                G_MID:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid_calc;
                        e_reg     <= e_calc;
                        m_reg     <= m_init;
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= G_LOG;
                    end
                    else
                    begin
                        gain_reg  <= GAIN_W'(lo_reg);
                        done_reg  <= 1'b1;
                        state_reg <= G_IDLE;
                    end
                end
                G_LOG:
                begin
                    m_reg    <= m_next;
                    frac_reg <= {frac_reg[26:0], m2[29]};
                    it_reg   <= it_reg + 5'd1;
                    if (it_reg == 5'd27)
                    begin
                        state_reg <= G_MUL;
                    end
                end
                G_MUL:
                begin
                    pa_reg    <= 46'(d[31:16]) * 46'(LOG_FACTOR);
                    pb_reg    <= 46'(d[15:0]) * 46'(LOG_FACTOR);
                    state_reg <= G_CMP;
                end
                G_CMP:
                begin
                    if (fits)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - 16'd1;
                    end
                    state_reg <= G_MID;
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign gain = gain_reg;

endmodule

// File: rtl/rbam_dp.sv
module rbam_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbam_pkg::rbam_cmd_t   cmd,
    output rbam_pkg::rbam_sts_t   sts,
    input  logic [2:0]            func,
    input  logic [3:0]            channel,
    input  logic [7:0]            data_byte,
    input  logic signed [15:0]    level_mb,
    input  logic                  play_flag,
    input  logic                  mute_flag,
    output logic signed [15:0]    mix_sample,
    output logic [11:0]           fill_bytes,
    output logic                  refill_request,
    output logic                  byte_dropped
);
    import rbam_pkg::*;

    logic [PTR_W-1:0]  wp_reg   [CHANNELS];
    logic [PTR_W-1:0]  rp_reg   [CHANNELS];
    logic [GAIN_W-1:0] gain_reg [CHANNELS];
    logic              play_reg [CHANNELS];
    logic              mute_reg [CHANNELS];
    logic [7:0]        ring_mem [CHANNELS * RING_BYTES];

    logic [2:0]        func_reg;
    logic [3:0]        ch_reg;
    logic [7:0]        byte_reg;
    logic [15:0]       level_reg;
    logic              pf_reg;
    logic              mf_reg;
    logic              dropped_reg;
    logic [CH_W-1:0]   scan_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [7:0]        lo_reg;
    logic [7:0]        rdata_reg;
    logic [31:0]       prod_reg;
    logic              neg_reg;

    logic signed [15:0] mix_reg;
    logic [FILL_W-1:0]  fill_out_reg;
    logic               refill_reg;
    logic               dropped_out_reg;

    logic [CH_W-1:0]   idx;
    logic [PTR_W-1:0]  wp;
    logic [PTR_W-1:0]  rp;
    logic [CNT_W-1:0]  fill;
    logic              ch_valid;
    logic              full;
    logic [ADDR_W-1:0] addr;
    logic              mem_we;
    logic              mem_re;
    logic [15:0]       raw;
    logic [15:0]       mag;
    logic [16:0]       term;
    logic signed [15:0] sat;
    logic              gain_done;
    logic [GAIN_W-1:0] gain_new;

    rbam_gain u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.gain_start),
        .level (level_reg),
        .done  (gain_done),
        .gain  (gain_new)
    );

    always_comb
    begin
        idx      = cmd.use_scan ? scan_reg : CH_W'(ch_reg);
        wp       = wp_reg[idx];
        rp       = rp_reg[idx];
        fill     = ring_fill(wp, rp);
        ch_valid = int'(ch_reg) < CHANNELS;
        full     = fill >= CNT_W'(RING_BYTES - 1);
        mem_we   = cmd.exec && ch_valid && (func_reg == FUNC_WRITE) && !full;
        mem_re   = cmd.rd_lo || cmd.rd_hi;
        if (mem_we)
        begin
            addr = {idx, wp};
        end
        else if (cmd.rd_hi)
        begin
            addr = {idx, ring_next(rp)};
        end
        else
        begin
            addr = {idx, rp};
        end
        raw  = {rdata_reg, lo_reg};
        mag  = raw[15] ? (~raw + 16'd1) : raw;
        term = {1'b0, prod_reg[30:15]};
        if (sum_reg > SUM_W'(32767))
        begin
            sat = 16'sh7FFF;
        end
        else if (sum_reg < -SUM_W'(32768))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = sum_reg[15:0];
        end
        sts.func      = func_reg;
        sts.ch_valid  = ch_valid;
        sts.eligible  = play_reg[idx] && !mute_reg[idx] && (fill >= CNT_W'(2));
        sts.last_ch   = scan_reg == CH_W'(CHANNELS - 1);
        sts.gain_done = gain_done;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[addr] <= byte_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= ring_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]   <= '0;
                rp_reg[i]   <= '0;
                gain_reg[i] <= GAIN_UNITY;
                play_reg[i] <= 1'b0;
                mute_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.exec && ch_valid)
            begin
                case (func_reg)
                    FUNC_WRITE:
                    begin
                        if (!full)
                        begin
                            wp_reg[idx] <= ring_next(wp);
                        end
                    end
                    FUNC_PLAY:
                    begin
                        play_reg[idx] <= pf_reg;
                        mute_reg[idx] <= mf_reg;
                    end
                    FUNC_CLEAR:
                    begin
                        wp_reg[idx] <= '0;
                        rp_reg[idx] <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.gain_store)
            begin
                gain_reg[idx] <= gain_new;
            end
            if (cmd.mul)
            begin
                rp_reg[idx] <= ring_next(ring_next(rp));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg    <= func;
            ch_reg      <= channel;
            byte_reg    <= data_byte;
            level_reg   <= level_mb;
            pf_reg      <= play_flag;
            mf_reg      <= mute_flag;
            dropped_reg <= 1'b0;
        end
        if (cmd.exec && ch_valid && (func_reg == FUNC_WRITE))
        begin
            dropped_reg <= full;
        end
        if (cmd.scan_clear)
        begin
            scan_reg <= '0;
            sum_reg  <= '0;
        end
        if (cmd.next_ch)
        begin
            scan_reg <= scan_reg + CH_W'(1);
        end
        if (cmd.rd_hi)
        begin
            lo_reg <= rdata_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= 32'(mag) * 32'(gain_reg[idx]);
            neg_reg  <= raw[15];
        end
        if (cmd.acc)
        begin
            sum_reg <= neg_reg ? (sum_reg - SUM_W'(term)) : (sum_reg + SUM_W'(term));
        end
        if (cmd.load_result)
        begin
            mix_reg         <= (func_reg == FUNC_TICK) ? sat : 16'sd0;
            fill_out_reg    <= ch_valid ? FILL_W'(fill) : '0;
            refill_reg      <= ch_valid && (fill < CNT_W'(RING_BYTES / 2));
            dropped_out_reg <= dropped_reg;
        end
    end

    assign mix_sample     = mix_reg;
    assign fill_bytes     = fill_out_reg;
    assign refill_request = refill_reg;
    assign byte_dropped   = dropped_out_reg;

endmodule

// File: rtl/rbam_ctrl.sv
module rbam_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  rbam_pkg::rbam_sts_t   sts,
    output rbam_pkg::rbam_cmd_t   cmd
);
    import rbam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_GAIN_WAIT,
        S_TCHK,
        S_TRD0,
        S_TMUL,
        S_TACC,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   slot_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        slot_free  = !result_valid_reg || result_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.func)
                    FUNC_TICK:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_TCHK;
                    end
                    FUNC_LEVEL:
                    begin
                        if (sts.ch_valid)
                        begin
                            cmd.gain_start = 1'b1;
                            state_next     = S_GAIN_WAIT;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_GAIN_WAIT:
            begin
                if (sts.gain_done)
                begin
                    cmd.gain_store = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_TCHK:
            begin
                cmd.use_scan = 1'b1;
                if (sts.eligible)
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = S_TRD0;
                end
                else
                begin
                    cmd.next_ch = 1'b1;
                    if (sts.last_ch)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_TRD0:
            begin
                cmd.use_scan = 1'b1;
                cmd.rd_hi    = 1'b1;
                state_next   = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.use_scan = 1'b1;
                cmd.mul      = 1'b1;
                state_next   = S_TACC;
            end
            S_TACC:
            begin
                cmd.use_scan = 1'b1;
                cmd.acc      = 1'b1;
                cmd.next_ch  = 1'b1;
                state_next   = sts.last_ch ? S_FINISH : S_TCHK;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign item_ready   = state_reg == S_IDLE;
    assign result_valid = result_valid_reg;

endmodule

// File: rtl/ring_buffered_audio_mixer.sv
// Mixer for 16 channels, each with a 4096-byte ring that holds up to 4095 bytes.
// One item is taken at a time and gives exactly one result, held in an output
// register so the next item can be taken while the result waits. Write, set
// play/mute, clear and status pass from dispatch straight to finish. A mix tick
// walks the channels one by one: a skipped channel takes only the check, and one
// that gives up a sample also takes two ring reads on the single memory port, one
// multiply and one accumulate. Set level with a negative level runs a binary
// search of at most 16 steps, each a bit-serial log2 of 28 squarings, a multiply
// and a compare; a non-negative level sets unity gain without the search.
module ring_buffered_audio_mixer (
    input  logic          clk,
    input  logic          rst_n,
    rbam_item_if.sink     item,
    rbam_result_if.source result
);
    import rbam_pkg::*;

    rbam_cmd_t cmd;
    rbam_sts_t sts;

    rbam_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    rbam_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (item.func),
        .channel        (item.channel),
        .data_byte      (item.data_byte),
        .level_mb       (item.level_mb),
        .play_flag      (item.play_flag),
        .mute_flag      (item.mute_flag),
        .mix_sample     (result.mix_sample),
        .fill_bytes     (result.fill_bytes),
        .refill_request (result.refill_request),
        .byte_dropped   (result.byte_dropped)
    );

endmodule

// File: bench/tb_ring_buffered_audio_mixer.sv
module tb_ring_buffered_audio_mixer;
    timeunit 1ns;
    timeprecision 1ps;
    import rbam_pkg::*;

    typedef struct {
        logic [2:0]         func;
        logic [3:0]         channel;
        logic [7:0]         data_byte;
        logic signed [15:0] level_mb;
        logic               play_flag;
        logic               mute_flag;
    } mix_cmd_t;

    typedef struct {
        logic signed [15:0] mix_sample;
        logic [11:0]        fill_bytes;
        logic               refill_request;
        logic               byte_dropped;
    } mix_out_t;

    typedef struct {
        mix_cmd_t cmd;
        bit       typed;
        mix_out_t want;
    } cmd_row_t;

    logic clk;
    logic rst_n;
    rbam_item_if   item();
    rbam_result_if result();

    ring_buffered_audio_mixer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    logic [7:0]  shadow_ring [CHANNELS][RING_BYTES];
    logic [11:0] shadow_wr [CHANNELS];
    logic [11:0] shadow_rd [CHANNELS];
    logic [16:0] shadow_gain [CHANNELS];
    bit          shadow_play [CHANNELS];
    bit          shadow_mute [CHANNELS];

    mix_out_t pending_results[$];
    cmd_row_t cmd_queue[$];
    int       fail_count;
    int       quiet_cycles;
    bit       sender_done;
    bit       calm_phase;
    bit       hold_off;
    cmd_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int ring_count(int ch);
        return (shadow_wr[ch] >= shadow_rd[ch]) ? shadow_wr[ch] - shadow_rd[ch]
                                                : shadow_wr[ch] + RING_BYTES - shadow_rd[ch];
    endfunction

    function automatic logic [63:0] log2_fixed(int g);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        frac = 0;
        while (e < 15 && (g >> (e + 1)) != 0)
        begin
            e++;
        end
        m = 64'(g) << (28 - e);
        for (int i = 0; i < 28; i++)
        begin
            m = (m * m) >> 28;
            frac = frac << 1;
            if (m >= (64'd1 << 29))
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << 28) | frac;
    endfunction

    function automatic int level_to_gain(logic [15:0] raw);
        int          lo;
        int          hi;
        int          mid;
        logic [63:0] target;
        logic [63:0] d;
        bit          ok;
        lo = 0;
        hi = 32768;
        if (!raw[15])
        begin
            return 32768;
        end
        target = 64'(32'h10000 - raw) << 48;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            d = (64'd15 << 28) - log2_fixed(mid);
            ok = (d * 64'(LOG_FACTOR)) >= target;
            if (ok)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    function automatic mix_out_t predict_mix(mix_cmd_t c);
        mix_out_t o;
        int       ch;
        int       sum;
        int       s;
        int       mag;
        logic [11:0] r2;
        o = '{0, 0, 0, 0};
        ch = c.channel;
        if (c.func == FUNC_TICK)
        begin
            sum = 0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (shadow_play[k] && !shadow_mute[k] && ring_count(k) >= 2)
                begin
                    r2 = shadow_rd[k] + 12'd1;
                    s = $signed({shadow_ring[k][r2], shadow_ring[k][shadow_rd[k]]});
                    shadow_rd[k] = r2 + 12'd1;
                    mag = (s < 0) ? -s : s;
                    mag = (mag * shadow_gain[k]) >>> 15;
                    sum += (s < 0) ? -mag : mag;
                end
            end
            if (sum > 32767)
            begin
                sum = 32767;
            end
            if (sum < -32768)
            begin
                sum = -32768;
            end
            o.mix_sample = 16'(sum);
        end
        else if (c.func == FUNC_WRITE)
        begin
            if (ring_count(ch) >= RING_BYTES - 1)
            begin
                o.byte_dropped = 1'b1;
            end
            else
            begin
                shadow_ring[ch][shadow_wr[ch]] = c.data_byte;
                shadow_wr[ch] = shadow_wr[ch] + 12'd1;
            end
        end
        else if (c.func == FUNC_LEVEL)
        begin
            shadow_gain[ch] = 17'(level_to_gain(c.level_mb));
        end
        else if (c.func == FUNC_PLAY)
        begin
            shadow_play[ch] = c.play_flag;
            shadow_mute[ch] = c.mute_flag;
        end
        else if (c.func == FUNC_CLEAR)
        begin
            shadow_wr[ch] = 0;
            shadow_rd[ch] = 0;
        end
        o.fill_bytes = 12'(ring_count(ch));
        o.refill_request = ring_count(ch) < RING_BYTES / 2;
        return o;
    endfunction

    function automatic mix_cmd_t make_cmd(logic [2:0] f, int ch, int b, int lv, bit p, bit m);
        mix_cmd_t c;
        c.func = f;
        c.channel = 4'(ch);
        c.data_byte = 8'(b);
        c.level_mb = 16'(lv);
        c.play_flag = p;
        c.mute_flag = m;
        return c;
    endfunction

    function automatic cmd_row_t plain_row(mix_cmd_t c);
        cmd_row_t r;
        r.cmd = c;
        r.typed = 1'b0;
        r.want = '{0, 0, 0, 0};
        return r;
    endfunction

    function automatic mix_cmd_t random_cmd(bit loud);
        mix_cmd_t c;
        int       pick;
        c = make_cmd(FUNC_STATUS, $urandom_range(0, 3), $urandom_range(0, 255),
                     $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            c.channel = 4'($urandom_range(0, 15));
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            c.func = FUNC_WRITE;
        end
        else if (pick < 80)
        begin
            c.func = FUNC_TICK;
        end
        else if (pick < 85)
        begin
            c.func = FUNC_LEVEL;
            if ($urandom_range(0, 2) != 0)
            begin
                c.level_mb = -16'($urandom_range(0, 4000));
            end
        end
        else if (pick < 93)
        begin
            c.func = FUNC_PLAY;
            c.play_flag = $urandom_range(0, 3) != 0;
            c.mute_flag = $urandom_range(0, 4) == 0;
        end
        else if (pick < 95)
        begin
            c.func = FUNC_CLEAR;
        end
        else
        begin
            c.func = 3'($urandom_range(5, 7));
        end
        if (loud && c.func == FUNC_TICK)
        begin
            c.func = FUNC_WRITE;
        end
        return c;
    endfunction

    task automatic send_cmd(mix_cmd_t c);
        item.valid     <= 1'b1;
        item.func      <= c.func;
        item.channel   <= c.channel;
        item.data_byte <= c.data_byte;
        item.level_mb  <= c.level_mb;
        item.play_flag <= c.play_flag;
        item.mute_flag <= c.mute_flag;
        do
        begin
            @(posedge clk);
        end
        while (!item.ready);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm_phase && $urandom_range(0, 5) == 0)
        begin
            item.valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        mix_out_t  w;
        mix_out_t  p;
        cmd_row_t  r;
        if (rst_n && item.valid && item.ready)
        begin
            r = cmd_queue.pop_front();
            p = predict_mix(r.cmd);
            pending_results.push_back(r.typed ? r.want : p);
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation waiting");
                fail_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (result.mix_sample !== w.mix_sample)
                begin
                    $error("mix_sample expected %0d actual %0d", w.mix_sample,
                           result.mix_sample);
                    fail_count++;
                end
                if (result.fill_bytes !== w.fill_bytes)
                begin
                    $error("fill_bytes expected %0d actual %0d", w.fill_bytes,
                           result.fill_bytes);
                    fail_count++;
                end
                if (result.refill_request !== w.refill_request)
                begin
                    $error("refill_request expected %0d actual %0d", w.refill_request,
                           result.refill_request);
                    fail_count++;
                end
                if (result.byte_dropped !== w.byte_dropped)
                begin
                    $error("byte_dropped expected %0d actual %0d", w.byte_dropped,
                           result.byte_dropped);
                    fail_count++;
                end
            end
        end
    end

    // typed rows are checked against the table value instead of the predictor
    task automatic run_row(cmd_row_t row);
        cmd_queue.push_back(row);
        send_cmd(row.cmd);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 0;
                result.ready <= 1'b1;
            end
            else if (!calm_phase && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                stall = $urandom_range(1, 13);
                repeat (stall) @(posedge clk);
                result.ready <= 1'b1;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        item.valid = 1'b0;
        item.func = FUNC_STATUS;
        item.channel = 0;
        item.data_byte = 0;
        item.level_mb = 0;
        item.play_flag = 0;
        item.mute_flag = 0;
        rst_n = 1'b0;
        fail_count = 0;
        sender_done = 0;
        calm_phase = 0;
        hold_off = 0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            shadow_wr[k] = 0;
            shadow_rd[k] = 0;
            shadow_gain[k] = 17'd32768;
            shadow_play[k] = 0;
            shadow_mute[k] = 0;
        end
        directed_rows = '{
            '{make_cmd(FUNC_STATUS, 15, 0, 0, 0, 0), 1, '{0, 0, 1, 0}},
            '{make_cmd(FUNC_TICK, 0, 0, 0, 0, 0), 1, '{0, 0, 1, 0}},
            '{make_cmd(3'd7, 3, 255, -1, 1, 1), 1, '{0, 0, 1, 0}},
            '{make_cmd(3'd6, 0, 0, 0, 0, 0), 1, '{0, 0, 1, 0}},
            '{make_cmd(FUNC_WRITE, 0, 8'hff, 0, 0, 0), 1, '{0, 1, 1, 0}},
            '{make_cmd(FUNC_WRITE, 0, 8'h7f, 0, 0, 0), 1, '{0, 2, 1, 0}},
            '{make_cmd(FUNC_WRITE, 1, 8'h00, 0, 0, 0), 1, '{0, 1, 1, 0}},
            '{make_cmd(FUNC_WRITE, 1, 8'h80, 0, 0, 0), 1, '{0, 2, 1, 0}},
            '{make_cmd(FUNC_WRITE, 2, 8'h01, 0, 0, 0), 1, '{0, 1, 1, 0}},
            '{make_cmd(FUNC_PLAY, 0, 0, 0, 1, 0), 1, '{0, 2, 1, 0}},
            '{make_cmd(FUNC_PLAY, 1, 0, 0, 1, 0), 1, '{0, 2, 1, 0}},
            '{make_cmd(FUNC_PLAY, 2, 0, 0, 1, 0), 1, '{0, 1, 1, 0}},
            '{make_cmd(FUNC_TICK, 1, 0, 0, 0, 0), 1, '{-16'sd1, 0, 1, 0}},
            '{make_cmd(FUNC_LEVEL, 4, 0, 32767, 0, 0), 1, '{0, 0, 1, 0}},
            '{make_cmd(FUNC_LEVEL, 5, 0, -32768, 0, 0), 0, '{0, 0, 0, 0}},
            '{make_cmd(FUNC_LEVEL, 6, 0, -1, 0, 0), 0, '{0, 0, 0, 0}},
            '{make_cmd(FUNC_LEVEL, 7, 0, -602, 0, 0), 0, '{0, 0, 0, 0}},
            '{make_cmd(FUNC_LEVEL, 2, 0, -2000, 0, 0), 0, '{0, 0, 0, 0}},
            '{make_cmd(FUNC_WRITE, 2, 8'h40, 0, 0, 0), 1, '{0, 2, 1, 0}},
            '{make_cmd(FUNC_TICK, 2, 0, 0, 0, 0), 0, '{0, 0, 0, 0}},
            '{make_cmd(FUNC_PLAY, 3, 0, 0, 1, 1), 1, '{0, 0, 1, 0}},
            '{make_cmd(FUNC_CLEAR, 2, 0, 0, 0, 0), 1, '{0, 0, 1, 0}},
            '{make_cmd(FUNC_STATUS, 2, 0, 0, 1, 1), 1, '{0, 0, 1, 0}}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            run_row(directed_rows[i]);
            sender_gap();
        end
        // fill channel 5 to the top and beyond, with the receiver first held off
        hold_off = 1;
        for (int i = 0; i < RING_BYTES + 2; i++)
        begin
            mix_cmd_t c;
            c = make_cmd(FUNC_WRITE, 5, $urandom_range(0, 255), 0, 0, 0);
            cmd_queue.push_back(plain_row(c));
            send_cmd(c);
        end
        begin
            mix_cmd_t c;
            c = make_cmd(FUNC_CLEAR, 5, 0, 0, 0, 0);
            cmd_queue.push_back(plain_row(c));
            send_cmd(c);
        end
        for (int i = 0; i < 1650; i++)
        begin
            mix_cmd_t c;
            if (i == 1400)
            begin
                calm_phase = 1;
            end
            c = random_cmd(i % 200 < 40);
            cmd_queue.push_back(plain_row(c));
            send_cmd(c);
            sender_gap();
        end
        item.valid <= 1'b0;
        sender_done = 1;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/rbam_pkg.sv
rtl/rbam_item_if.sv
rtl/rbam_result_if.sv
rtl/rbam_gain.sv
rtl/rbam_dp.sv
rtl/rbam_ctrl.sv
rtl/ring_buffered_audio_mixer.sv
bench/tb_ring_buffered_audio_mixer.sv
